FILE: hw/rtl/hdu_pkg.sv
// shared types and constants for the half-duplex uart
`default_nettype none
package hdu_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [1:0] ACT_IDLE = 2'd0;
  localparam logic [1:0] ACT_TX   = 2'd1;
  localparam logic [1:0] ACT_RX   = 2'd2;

  localparam logic [3:0] FRAME_BITS = 4'd10;

  localparam logic CFG_BIT_PERIOD = 1'b0;
  localparam logic CFG_RX_ENABLE  = 1'b1;

  typedef struct packed {
    logic       tx_level;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       tx_busy;
    logic       rx_busy;
    logic       send_refused;
  } hdu_result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/hdu_core.sv
// per-tick uart state update: transmit framing, receive sampling, frame check
`default_nettype none
module hdu_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire logic                          rx_level,
  input  wire logic                          send_valid,
  input  wire logic [7:0]                    send_byte,
  input  wire logic [hdu_pkg::PERIOD_W-1:0]  bit_period,
  input  wire logic                          rx_enable,
  output hdu_pkg::hdu_result_t               result
);
  import hdu_pkg::*;

  logic [1:0]          act_r, act_nxt;
  logic [PERIOD_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]          bits_r, bits_nxt;
  logic [9:0]          txs_r, txs_nxt;
  logic [9:0]          rxs_r, rxs_nxt;
  logic                prev_r, prev_nxt;
  logic                line_r, line_nxt;
  logic                nlev_r, nlev_nxt;
  logic [7:0]          held_r, held_nxt;
  logic                got;
  logic                refused;
  logic                fall;
  logic                evt;

  always_comb begin
    act_nxt  = act_r;
    cnt_nxt  = cnt_r;
    bits_nxt = bits_r;
    txs_nxt  = txs_r;
    rxs_nxt  = rxs_r;
    line_nxt = line_r;
    nlev_nxt = nlev_r;
    held_nxt = held_r;
    prev_nxt = rx_level;
    got      = 1'b0;
    refused  = 1'b0;
    fall     = prev_r & ~rx_level;
    evt      = (cnt_r <= PERIOD_W'(1));
    priority if (act_r != ACT_RX && rx_enable && fall) begin
      act_nxt  = ACT_RX;
      cnt_nxt  = bit_period >> 1;
      bits_nxt = FRAME_BITS;
      rxs_nxt  = '0;
      nlev_nxt = 1'b1;
      refused  = send_valid;
    end else if (send_valid && act_r == ACT_IDLE) begin
      act_nxt  = ACT_TX;
      cnt_nxt  = bit_period;
      bits_nxt = FRAME_BITS;
      txs_nxt  = {1'b1, send_byte, 1'b0};
      nlev_nxt = 1'b1;
    end else begin
      refused = send_valid;
      if (act_r == ACT_TX || act_r == ACT_RX) begin
        if (evt) begin
          cnt_nxt  = bit_period;
          line_nxt = nlev_r;
          priority if (bits_r == 4'd0) begin
            act_nxt = ACT_IDLE;
            if (act_r == ACT_RX && rxs_r[9] && !rxs_r[0]) begin
              held_nxt = rxs_r[8:1];
              got      = 1'b1;
            end
          end else if (act_r == ACT_TX) begin
            nlev_nxt = txs_r[0];
            txs_nxt  = {1'b0, txs_r[9:1]};
            bits_nxt = bits_r - 4'd1;
          end else begin
            rxs_nxt  = {rx_level, rxs_r[9:1]};
            bits_nxt = bits_r - 4'd1;
          end
        end else begin
          cnt_nxt = cnt_r - PERIOD_W'(1);
        end
      end else begin
        act_nxt = ACT_IDLE;
      end
    end
  end

  always_comb begin
    result.tx_level     = line_nxt;
    result.rx_valid     = got;
    result.rx_byte      = held_nxt;
    result.tx_busy      = (act_nxt == ACT_TX);
    result.rx_busy      = (act_nxt == ACT_RX);
    result.send_refused = refused;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= ACT_IDLE;
      cnt_r  <= '0;
      bits_r <= '0;
      txs_r  <= '0;
      rxs_r  <= '0;
      prev_r <= 1'b1;
      line_r <= 1'b1;
      nlev_r <= 1'b1;
      held_r <= '0;
    end else if (step) begin
      act_r  <= act_nxt;
      cnt_r  <= cnt_nxt;
      bits_r <= bits_nxt;
      txs_r  <= txs_nxt;
      rxs_r  <= rxs_nxt;
      prev_r <= prev_nxt;
      line_r <= line_nxt;
      nlev_r <= nlev_nxt;
      held_r <= held_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/half_duplex_uart_8n1.sv
// half-duplex 8n1 uart top level: request register, tick update, result register
// a request enters the input register; its result then goes to the result register on the outputs
// throughput: one request per cycle while the result register is not held, one result per request
// the input register and the per-tick state update in the core set that figure
// ready drops only while the input register is full and the result register is full and not taken
// reset (synchronous, rst_n low): lines at mark, idle, bit_period 104, rx enabled
`default_nettype none
module half_duplex_uart_8n1 (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_index,
  input  wire logic [hdu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_rx_level,
  input  wire logic                          in_send_valid,
  input  wire logic [7:0]                    in_send_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_tx_level,
  output logic                               out_rx_valid,
  output logic [7:0]                         out_rx_byte,
  output logic                               out_tx_busy,
  output logic                               out_rx_busy,
  output logic                               out_send_refused
);
  import hdu_pkg::*;

  logic [PERIOD_W-1:0] bit_period_r;
  logic                rx_enable_r;
  logic                s1_valid_r;
  logic                s1_rx_r;
  logic                s1_send_r;
  logic [7:0]          s1_byte_r;
  logic                out_valid_r;
  hdu_result_t         out_r;
  hdu_result_t         core_result;
  logic                advance;
  logic                step;

  assign advance  = !out_valid_r || out_ready;
  assign step     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= PERIOD_W'(104);
      rx_enable_r  <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BIT_PERIOD: bit_period_r <= cfg_wdata[PERIOD_W-1:0];
        CFG_RX_ENABLE:  rx_enable_r  <= cfg_wdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_rx_r   <= in_rx_level;
      s1_send_r <= in_send_valid;
      s1_byte_r <= in_send_byte;
    end
  end

  hdu_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .rx_level   (s1_rx_r),
    .send_valid (s1_send_r),
    .send_byte  (s1_byte_r),
    .bit_period (bit_period_r),
    .rx_enable  (rx_enable_r),
    .result     (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= core_result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tx_level     = out_r.tx_level;
  assign out_rx_valid     = out_r.rx_valid;
  assign out_rx_byte      = out_r.rx_byte;
  assign out_tx_busy      = out_r.tx_busy;
  assign out_rx_busy      = out_r.rx_busy;
  assign out_send_refused = out_r.send_refused;

  // transmit and receive never run together
  a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.tx_busy && out_r.rx_busy))
    else $error("tx and rx busy together");

  // a completed frame leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.rx_valid) |-> (!out_r.tx_busy && !out_r.rx_busy))
    else $error("rx_valid while busy");

  // a stalled request stays in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_byte_r) && $stable(s1_send_r)))
    else $error("stalled request lost");

  // a held result is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_r))
    else $error("held result changed");

endmodule
`default_nettype wire

FILE: test/uart_frame_checker.sv
// line status checker for the half-duplex uart: tracks requests, predicts and compares results
module uart_frame_checker
  import hdu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_rx_level,
  input  logic                  in_send_valid,
  input  logic [7:0]            in_send_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_tx_level,
  input  logic                  out_rx_valid,
  input  logic [7:0]            out_rx_byte,
  input  logic                  out_tx_busy,
  input  logic                  out_rx_busy,
  input  logic                  out_send_refused,
  output int                    fail_count,
  output int                    pending
);

  localparam logic [PERIOD_W-1:0] RESET_PERIOD = 16'd104;

  logic [PERIOD_W-1:0] bit_period;
  logic                rx_enable;
  logic [1:0]          activity;
  logic [PERIOD_W-1:0] countdown;
  logic [3:0]          bits_left;
  logic [9:0]          tx_shift;
  logic [10:0]         rx_shift;
  logic                prev_rx;
  logic                line_out;
  logic                next_level;
  logic [7:0]          held_byte;
  hdu_result_t         predicted_status[$];

  task automatic advance_uart(input logic rx, input logic send, input logic [7:0] data,
                              output hdu_result_t status);
    logic got;
    logic refused;
    logic fire;
    got = 1'b0;
    refused = 1'b0;
    fire = 1'b0;
    if (activity != ACT_RX && rx_enable && prev_rx && !rx) begin
      // receive start wins over a transmit and over a send on the same tick
      activity = ACT_RX;
      countdown = bit_period >> 1;
      bits_left = FRAME_BITS;
      rx_shift = '0;
      next_level = 1'b1;
      refused = send;
    end else if (send && activity == ACT_IDLE) begin
      activity = ACT_TX;
      countdown = bit_period;
      bits_left = FRAME_BITS;
      tx_shift = {1'b1, data, 1'b0};
      next_level = 1'b1;
    end else begin
      refused = send;
      if (activity != ACT_IDLE) begin
        fire = (countdown <= 1);
        if (fire) begin
          countdown = bit_period;
          line_out = next_level;
        end else begin
          countdown = countdown - 1'b1;
        end
      end
      if (fire && activity == ACT_TX) begin
        if (bits_left == 0) begin
          activity = ACT_IDLE;
        end else begin
          next_level = tx_shift[0];
          tx_shift = tx_shift >> 1;
          bits_left = bits_left - 1'b1;
        end
      end else if (fire && activity == ACT_RX) begin
        if (bits_left == 0) begin
          activity = ACT_IDLE;
          if (rx_shift[9] && !rx_shift[0]) begin
            held_byte = rx_shift[8:1];
            got = 1'b1;
          end
        end else begin
          rx_shift = {1'b0, rx, rx_shift[9:1]};
          bits_left = bits_left - 1'b1;
        end
      end
    end
    prev_rx = rx;
    status.tx_level = line_out;
    status.rx_valid = got;
    status.rx_byte = held_byte;
    status.tx_busy = (activity == ACT_TX);
    status.rx_busy = (activity == ACT_RX);
    status.send_refused = refused;
  endtask

  task automatic check_field(input string field, input int unsigned want, input int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", field, want, seen);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    hdu_result_t want;
    if (!rst_n) begin
      bit_period = RESET_PERIOD;
      rx_enable = 1'b1;
      activity = ACT_IDLE;
      countdown = '0;
      bits_left = '0;
      tx_shift = '0;
      rx_shift = '0;
      prev_rx = 1'b1;
      line_out = 1'b1;
      next_level = 1'b1;
      held_byte = '0;
      predicted_status.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_BIT_PERIOD) begin
          bit_period = cfg_wdata;
        end else begin
          rx_enable = cfg_wdata[0];
        end
      end
      if (out_valid && out_ready) begin
        if (predicted_status.size() == 0) begin
          $error("line status with no request outstanding");
          fail_count++;
        end else begin
          want = predicted_status.pop_front();
          check_field("tx_level", want.tx_level, out_tx_level);
          check_field("rx_valid", want.rx_valid, out_rx_valid);
          check_field("rx_byte", want.rx_byte, out_rx_byte);
          check_field("tx_busy", want.tx_busy, out_tx_busy);
          check_field("rx_busy", want.rx_busy, out_rx_busy);
          check_field("send_refused", want.send_refused, out_send_refused);
        end
      end
      if (in_valid && in_ready) begin
        advance_uart(in_rx_level, in_send_valid, in_send_byte, want);
        predicted_status.push_back(want);
      end
    end
    pending = predicted_status.size();
  end

endmodule

FILE: test/testbench.sv
// top-level testbench for the half-duplex uart: framed line stimulus, handshake pacing, verdict
module testbench;
  import hdu_pkg::*;

  localparam int unsigned ITEM_TARGET = 1350;
  localparam int unsigned LONG_HOLD = 400;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_index = CFG_BIT_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_rx_level = 1'b1;
  logic                  in_send_valid = 1'b0;
  logic [7:0]            in_send_byte = '0;
  logic                  out_ready = 1'b0;
  wire logic             in_ready;
  wire logic             out_valid;
  wire logic             out_tx_level;
  wire logic             out_rx_valid;
  wire logic [7:0]       out_rx_byte;
  wire logic             out_tx_busy;
  wire logic             out_rx_busy;
  wire logic             out_send_refused;
  int                    fail_count;
  int                    pending;

  int unsigned cur_period = 104;
  int unsigned active_items = 0;
  int unsigned results_taken = 0;
  bit          steady_send = 1'b0;
  bit          steady_take = 1'b0;

  half_duplex_uart_8n1 uut (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_rx_level, .in_send_valid, .in_send_byte,
    .out_valid, .out_ready, .out_tx_level, .out_rx_valid, .out_rx_byte,
    .out_tx_busy, .out_rx_busy, .out_send_refused
  );

  uart_frame_checker status_check (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_rx_level, .in_send_valid, .in_send_byte,
    .out_valid, .out_ready, .out_tx_level, .out_rx_valid, .out_rx_byte,
    .out_tx_busy, .out_rx_busy, .out_send_refused,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic drive_tick(input logic rx, input logic send, input logic [7:0] data,
                            input bit counted);
    int unsigned gap;
    if ($urandom_range(0, 63) == 0) steady_send = !steady_send;
    gap = steady_send ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_level <= rx;
    in_send_valid <= send;
    in_send_byte <= data;
    do @(posedge clk); while (!in_ready);
    if (counted) active_items++;
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_BIT_PERIOD) cur_period = value;
  endtask

  // each bit held one period from the edge; a period of one needs the start bit held twice
  task automatic rx_frame(input logic [7:0] data, input bit stop_ok, input bit send_on_edge);
    int unsigned half;
    int unsigned lead;
    int unsigned idx;
    logic [9:0] bits;
    half = ((cur_period >> 1) == 0) ? 1 : (cur_period >> 1);
    lead = ((cur_period >> 1) == 0) ? 1 : 0;
    bits = {stop_ok, data, 1'b0};
    for (int unsigned t = 0; t <= half + 10 * cur_period; t++) begin
      idx = (t < lead) ? 0 : (t - lead) / cur_period;
      drive_tick((idx < 10) ? bits[idx] : 1'b1,
                 (t == 0 && send_on_edge) || $urandom_range(0, 15) == 0, 8'($urandom), 1'b1);
    end
  endtask

  task automatic tx_frame(input logic [7:0] data, input bit abort);
    int unsigned span;
    span = 11 * cur_period;
    drive_tick(1'b1, 1'b1, data, 1'b1);
    if (abort) begin
      repeat ($urandom_range(1, span - 1)) drive_tick(1'b1, 1'b0, 8'($urandom), 1'b1);
      rx_frame(8'($urandom), 1'b1, 1'b0);
    end else begin
      for (int unsigned i = 1; i <= span + 1; i++)
        drive_tick(1'b1, i <= span && $urandom_range(0, 9) == 0, 8'($urandom), 1'b1);
    end
  endtask

  task automatic run_segment();
    int unsigned kind;
    int unsigned half;
    int unsigned width;
    kind = $urandom_range(0, 99);
    half = ((cur_period >> 1) == 0) ? 1 : (cur_period >> 1);
    repeat ($urandom_range(1, 3)) drive_tick(1'b1, 1'b0, 8'($urandom), 1'b0);
    if (kind < 35) begin
      rx_frame(8'($urandom), 1'b1, 1'b0);
    end else if (kind < 45) begin
      rx_frame(8'($urandom), 1'b0, 1'b0);
    end else if (kind < 55) begin
      // low pulse that is gone by the start sample
      width = $urandom_range(1, half);
      for (int unsigned t = 0; t <= half + 10 * cur_period; t++)
        drive_tick(t >= width, 1'b0, 8'($urandom), 1'b1);
    end else if (kind < 80) begin
      tx_frame(8'($urandom), 1'b0);
    end else if (kind < 90) begin
      tx_frame(8'($urandom), 1'b1);
    end else begin
      repeat ($urandom_range(4, 30))
        drive_tick(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, 8'($urandom), 1'b1);
      repeat (12 * cur_period + half + 2) drive_tick(1'b1, 1'b0, 8'($urandom), 1'b0);
    end
  endtask

  initial begin : stimulus
    int unsigned pick;
    int unsigned period;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // transmit at reset period, then a receive start with a send aborts it
    drive_tick(1'b1, 1'b1, 8'hFF, 1'b1);
    repeat (3) drive_tick(1'b1, 1'b0, 8'h00, 1'b1);
    write_reg(CFG_BIT_PERIOD, 16'd1);
    rx_frame(8'hFF, 1'b1, 1'b1);
    tx_frame(8'h00, 1'b0);
    // widest period, cut short by a receive start
    write_reg(CFG_BIT_PERIOD, 16'hFFFF);
    drive_tick(1'b1, 1'b1, 8'h5A, 1'b1);
    repeat (10) drive_tick(1'b1, 1'b0, 8'hA5, 1'b1);
    write_reg(CFG_BIT_PERIOD, 16'd4);
    rx_frame(8'h3C, 1'b1, 1'b0);
    while (active_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) period = $urandom_range(4, 9);
      else if (pick < 9) period = $urandom_range(10, 16);
      else period = $urandom_range(1, 3);
      write_reg(CFG_BIT_PERIOD, CFG_DATA_W'(period));
      write_reg(CFG_RX_ENABLE, CFG_DATA_W'($urandom_range(0, 5) != 0));
      repeat (6) if (active_items < ITEM_TARGET) run_segment();
    end
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned hold;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) steady_take = !steady_take;
      hold = steady_take ? 0 : $urandom_range(0, 13);
      // long stall so the block backs up into its input
      if (results_taken == 150 || results_taken == 900) hold = LONG_HOLD;
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_taken++;
    end
  end

endmodule
